// ===== hdl/lazy_range_add_range_sum_unit_defines.svh =====
// Assertion macros used by the bound checker module.
`ifndef LAZY_RANGE_ADD_RANGE_SUM_UNIT_DEFINES_SVH
`define LAZY_RANGE_ADD_RANGE_SUM_UNIT_DEFINES_SVH

// Check that b holds in the cycle after a.
`define LRAS_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("lras check failed");

// Check that b holds in the same cycle as a.
`define LRAS_ASSERT_SAME(label, a, b) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("lras check failed");

`endif

// ===== hdl/lras_pkg.sv =====
package lras_pkg;

  localparam int unsigned Size     = 1024;
  localparam int unsigned IdxW     = 11;
  localparam int unsigned AmtW     = 32;
  localparam int unsigned SumW     = 64;
  localparam int unsigned WinStW   = 10;
  localparam int unsigned MemDepth = 2048;
  localparam int unsigned CfgW     = 11;

  localparam logic FuncAdd = 1'b0;
  localparam logic FuncSum = 1'b1;

  localparam logic RegWinStart = 1'b0;
  localparam logic RegWinEnd   = 1'b1;

  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic load;
    logic res_clr;
    logic pt_init;
    logic qinit;
    logic sel;
    logic rd;
    logic wr;
    logic qacc;
    logic mul;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic live;
    logic func;
    logic r_full;
    logic upd_more;
    logic idx_zero;
    logic out_busy;
    logic cfg_hit;
  } status_t;

endpackage

// ===== hdl/lras_dp.sv =====
module lras_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lras_pkg::cmd_t                cmd_i,
  output lras_pkg::status_t             stat_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [lras_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          in_func_i,
  input  logic [lras_pkg::IdxW-1:0]     in_start_i,
  input  logic [lras_pkg::IdxW-1:0]     in_end_i,
  input  logic [lras_pkg::AmtW-1:0]     in_amt_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lras_pkg::SumW-1:0]     out_data_o
);

  localparam int unsigned IdxW = lras_pkg::IdxW;
  localparam int unsigned SumW = lras_pkg::SumW;

  logic [lras_pkg::WinStW-1:0] ws_q;
  logic [IdxW-1:0]             we_q;
  logic [IdxW-1:0]             clr_cnt_q;
  logic                        func_q, live_q;
  logic [IdxW-1:0]             l_q, r_q, p_q, idx_q;
  logic [lras_pkg::AmtW-1:0]   amt_q;
  logic [SumW-1:0]             delta1_q, delta2_q, acc1_q, acc2_q;
  logic [SumW-1:0]             prod_q, res_q, out_q, rd1_q, rd2_q;
  logic                        out_valid_q;

  logic [SumW-1:0] mem1 [lras_pkg::MemDepth];
  logic [SumW-1:0] mem2 [lras_pkg::MemDepth];

  // Window clipping of the incoming range
  logic [IdxW-1:0] lo, hi_cap, hi, cl, cr;
  logic            in_live;
  always_comb begin
    lo      = IdxW'(ws_q);
    hi_cap  = lo + IdxW'(lras_pkg::Size);
    hi      = (we_q < hi_cap) ? we_q : hi_cap;
    cl      = (in_start_i > lo) ? in_start_i : lo;
    cr      = (in_end_i < hi) ? in_end_i : hi;
    in_live = cl < cr;
  end

  // Update point setup
  logic [IdxW-1:0]        j;
  logic signed [43:0]     xj_n;
  logic [SumW-1:0]        x64, xj64;
  always_comb begin
    j    = cmd_i.sel ? r_q : l_q;
    xj_n = $signed(amt_q) * $signed({1'b0, j});
    xj64 = {{(SumW-44){xj_n[43]}}, xj_n};
    x64  = {{(SumW-lras_pkg::AmtW){amt_q[lras_pkg::AmtW-1]}}, amt_q};
  end

  logic [IdxW:0]   nxt;
  logic [IdxW-1:0] lowbit;
  logic [SumW-1:0] val;
  always_comb begin
    lowbit = idx_q & (~idx_q + IdxW'(1));
    nxt    = {1'b0, idx_q} + {1'b0, lowbit};
    val    = prod_q - acc2_q;
  end

  logic            wr_en;
  logic [IdxW-1:0] waddr;
  logic [SumW-1:0] wdata1, wdata2;
  assign wr_en  = cmd_i.clr_step | cmd_i.wr;
  assign waddr  = cmd_i.clr_step ? clr_cnt_q : idx_q;
  assign wdata1 = cmd_i.clr_step ? '0 : rd1_q + delta1_q;
  assign wdata2 = cmd_i.clr_step ? '0 : rd2_q + delta2_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem1[waddr] <= wdata1;
      mem2[waddr] <= wdata2;
    end
    if (cmd_i.rd) begin
      rd1_q <= mem1[idx_q];
      rd2_q <= mem2[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q        <= '0;
      we_q        <= IdxW'(lras_pkg::Size);
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lras_pkg::RegWinStart: ws_q <= cfg_wdata_i[lras_pkg::WinStW-1:0];
          lras_pkg::RegWinEnd:   we_q <= cfg_wdata_i[IdxW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clr_start) begin
        clr_cnt_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + IdxW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_func_i;
      live_q <= in_live;
      amt_q  <= in_amt_i;
      l_q    <= cl - lo;
      r_q    <= cr - lo;
    end
    if (cmd_i.pt_init) begin
      idx_q    <= j + IdxW'(1);
      delta1_q <= cmd_i.sel ? -x64 : x64;
      delta2_q <= cmd_i.sel ? -xj64 : xj64;
    end else if (cmd_i.qinit) begin
      idx_q <= cmd_i.sel ? l_q : r_q;
      p_q   <= cmd_i.sel ? l_q : r_q;
    end else if (cmd_i.wr) begin
      idx_q <= nxt[IdxW-1:0];
    end else if (cmd_i.qacc) begin
      idx_q <= idx_q & (idx_q - IdxW'(1));
    end
    if (cmd_i.qinit) begin
      acc1_q <= '0;
      acc2_q <= '0;
    end else if (cmd_i.qacc) begin
      acc1_q <= acc1_q + rd1_q;
      acc2_q <= acc2_q + rd2_q;
    end
    if (cmd_i.mul) begin
      prod_q <= acc1_q * SumW'(p_q);
    end
    if (cmd_i.res_clr) begin
      res_q <= '0;
    end else if (cmd_i.fin) begin
      res_q <= cmd_i.sel ? res_q - val : val;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  always_comb begin
    stat_o.clr_done = &clr_cnt_q;
    stat_o.live     = live_q;
    stat_o.func     = func_q;
    stat_o.r_full   = r_q == IdxW'(lras_pkg::Size);
    stat_o.upd_more = nxt <= (IdxW+1)'(lras_pkg::Size);
    stat_o.idx_zero = idx_q == '0;
    stat_o.out_busy = out_valid_q & ~out_ready_i;
    stat_o.cfg_hit  = cfg_we_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/lras_ctrl.sv =====
module lras_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lras_pkg::status_t stat_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output lras_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StDisp  = 4'd2;
  localparam logic [3:0] StUInit = 4'd3;
  localparam logic [3:0] StURd   = 4'd4;
  localparam logic [3:0] StUWr   = 4'd5;
  localparam logic [3:0] StQInit = 4'd6;
  localparam logic [3:0] StQRd   = 4'd7;
  localparam logic [3:0] StQAcc  = 4'd8;
  localparam logic [3:0] StQMul  = 4'd9;
  localparam logic [3:0] StQFin  = 4'd10;
  localparam logic [3:0] StOut   = 4'd11;

  logic [3:0] state_q, state_d;
  logic       sel_q, sel_d;

  assign in_ready_o = (state_q == StIdle) & ~stat_i.cfg_hit;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.sel = sel_q;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = StDisp;
        end
      end
      StDisp: begin
        sel_d = 1'b0;
        if (!stat_i.live) begin
          if (stat_i.func == lras_pkg::FuncSum) begin
            cmd_o.res_clr = 1'b1;
            state_d       = StOut;
          end else begin
            state_d = StIdle;
          end
        end else if (stat_i.func == lras_pkg::FuncSum) begin
          state_d = StQInit;
        end else begin
          state_d = StUInit;
        end
      end
      StUInit: begin
        if (sel_q && stat_i.r_full) begin
          state_d = StIdle;
        end else begin
          cmd_o.pt_init = 1'b1;
          state_d       = StURd;
        end
      end
      StURd: begin
        cmd_o.rd = 1'b1;
        state_d  = StUWr;
      end
      StUWr: begin
        cmd_o.wr = 1'b1;
        if (stat_i.upd_more) begin
          state_d = StURd;
        end else if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = StUInit;
        end else begin
          state_d = StIdle;
        end
      end
      StQInit: begin
        cmd_o.qinit = 1'b1;
        state_d     = StQRd;
      end
      StQRd: begin
        if (stat_i.idx_zero) begin
          state_d = StQMul;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = StQAcc;
        end
      end
      StQAcc: begin
        cmd_o.qacc = 1'b1;
        state_d    = StQRd;
      end
      StQMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StQFin;
      end
      StQFin: begin
        cmd_o.fin = 1'b1;
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = StQInit;
        end else begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StClear;
    endcase
    if (stat_i.cfg_hit) begin
      cmd_o          = '0;
      cmd_o.clr_start = 1'b1;
      state_d        = StClear;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule

// ===== hdl/lazy_range_add_range_sum_unit.sv =====
// Range add / range sum unit. One item at a time: an add makes two Fenwick walks of up to
// 11 steps each, a query two walks of up to 20 steps in all, bound by one memory access at
// a time. After its last memory read a query result passes the multiply and finish steps
// and waits in an output reg. After reset, and after every register write, a clearing pass
// runs over all 2048 memory words; no beat is accepted during it.
module lazy_range_add_range_sum_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write port
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [lras_pkg::CfgW-1:0] cfg_wdata_i,
  // Input beats
  input  logic                      s_tvalid_i,
  output logic                      s_tready_o,
  // [10:0] range_start, [21:11] range_end, [53:22] amount, [55:54] zero
  input  logic [55:0]               s_tdata_i,
  // [0] func
  input  logic                      s_tuser_i,
  // Result beats
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  // [63:0] range_sum
  output logic [63:0]               m_tdata_o
);

  lras_pkg::cmd_t    cmd;
  lras_pkg::status_t stat;
  logic              s_ready_unused_guard;

  // Sequencer: walks the two Fenwick trees (difference and index-weighted
  // difference) one memory access at a time.
  lras_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .in_valid_i (s_tvalid_i),
    .in_ready_o (s_ready_unused_guard),
    .cmd_o      (cmd)
  );

  assign s_tready_o = s_ready_unused_guard;

  // Datapath: window clipping, tree memories, accumulators, output register.
  lras_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_func_i   (s_tuser_i),
    .in_start_i  (s_tdata_i[10:0]),
    .in_end_i    (s_tdata_i[21:11]),
    .in_amt_i    (s_tdata_i[53:22]),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_data_o  (m_tdata_o)
  );

endmodule

// ===== hdl/lras_checker.sv =====
`include "lazy_range_add_range_sum_unit_defines.svh"

module lras_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_we_i,
  input logic                      cfg_idx_i,
  input logic [lras_pkg::CfgW-1:0] cfg_wdata_i,
  input logic                      s_tvalid_i,
  input logic                      s_tready_o,
  input logic [55:0]               s_tdata_i,
  input logic                      s_tuser_i,
  input logic                      m_tvalid_o,
  input logic                      m_tready_i,
  input logic [63:0]               m_tdata_o
);

  // Hold a stalled result beat.
  `LRAS_ASSERT_NEXT(a_out_hold, m_tvalid_o && !m_tready_i, m_tvalid_o && $stable(m_tdata_o))
  // Drop ready while an accepted beat is processed.
  `LRAS_ASSERT_NEXT(a_busy_after_accept, s_tvalid_i && s_tready_o, !s_tready_o)
  // Register write starts a clearing pass.
  `LRAS_ASSERT_NEXT(a_clear_after_cfg, cfg_we_i, !s_tready_o)
  // No result beat directly after an input beat.
  `LRAS_ASSERT_NEXT(a_no_instant_result, s_tvalid_i && s_tready_o, !$rose(m_tvalid_o))
  // Never accept an input beat during a register write.
  `LRAS_ASSERT_SAME(a_no_accept_on_cfg, cfg_we_i, !s_tready_o)

endmodule

bind lazy_range_add_range_sum_unit lras_checker u_lras_checker (.*);

// ===== tb/sv/lras_checker.sv =====
`timescale 1ns / 1ps

module lras_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [55:0] s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [63:0] m_tdata_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  logic [63:0] elem_val [0:2047];
  logic [9:0]  win_lo;
  logic [10:0] win_hi;
  logic [63:0] sum_q [$];

  task automatic clear_elems();
    for (int i = 0; i < 2048; i++) elem_val[i] = '0;
  endtask

  // Clip [rs,re) to the window, itself cut to SIZE positions.
  task automatic clip(input int unsigned rs, input int unsigned re,
                      output int unsigned a, output int unsigned b);
    int unsigned hi;
    hi = 32'(win_hi);
    if (hi > 32'(win_lo) + lras_pkg::Size) hi = 32'(win_lo) + lras_pkg::Size;
    a = (rs > 32'(win_lo)) ? rs : 32'(win_lo);
    b = (re < hi) ? re : hi;
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $realtime);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned a, b;
    logic [63:0] acc, amt;
    if (!rst_ni) begin
      win_lo = '0;
      win_hi = 11'd1024;
      clear_elems();
      sum_q.delete();
      fail_cnt_o = 0;
      pending_o = 0;
    end else begin
      // Results drain first; a result never belongs to a beat of the same edge.
      if (m_tvalid_i && m_tready_i) begin
        if (sum_q.size() == 0) report("unexpected result", m_tdata_i, '0);
        else begin
          acc = sum_q.pop_front();
          if (m_tdata_i !== acc) report("range_sum", m_tdata_i, acc);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        clip(32'(s_tdata_i[10:0]), 32'(s_tdata_i[21:11]), a, b);
        amt = {{32{s_tdata_i[53]}}, s_tdata_i[53:22]};
        if (s_tuser_i == lras_pkg::FuncAdd) begin
          for (int unsigned i = a; i < b; i++) elem_val[i] += amt;
        end else begin
          acc = '0;
          for (int unsigned i = a; i < b; i++) acc += elem_val[i];
          sum_q.push_back(acc);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == lras_pkg::RegWinStart) win_lo = cfg_wdata_i[9:0];
        else win_hi = cfg_wdata_i;
        clear_elems();
      end
      pending_o = sum_q.size();
    end
  end

  final if (sum_q.size() != 0) $display("MISMATCH %0d results never arrived", sum_q.size());
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  // [10:0] range_start, [21:11] range_end, [53:22] amount, [55:54] zero
  logic [55:0] s_tdata_i = '0;
  // [0] func
  logic        s_tuser_i = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  // [63:0] range_sum
  logic [63:0] m_tdata_o;

  int fail_cnt, pending;
  bit quiet;          // no idling on either side
  bit hold_req;       // ask the receiver for one long stall
  bit hold_done;      // the long stall has run
  int unsigned cycles;

  localparam int unsigned CycleLimit = 3_000_000;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  lazy_range_add_range_sum_unit uut (.*);

  lras_scoreboard chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_tvalid_i, .s_tready_i(s_tready_o), .s_tdata_i, .s_tuser_i,
    .m_tvalid_i(m_tvalid_o), .m_tready_i, .m_tdata_i(m_tdata_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // Watchdog: the slowest run includes a clearing pass per register write.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    int n;
    forever begin
      if (hold_req && !hold_done) begin
        m_tready_i <= 1'b0;
        // Hold long enough that the block fills up and drops s_tready.
        repeat (400) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(3) == 0) begin
        m_tready_i <= 1'b0;
        n = $urandom_range(13, 1);
        repeat (n) @(posedge clk_i);
      end else begin
        m_tready_i <= 1'b1;
        n = $urandom_range(20, 1);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Present one beat and hold it until accepted.
  task automatic send(input logic fn, input int unsigned rs, input int unsigned re,
                      input logic [31:0] amt);
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= fn;
    s_tdata_i  <= {2'b00, amt, re[10:0], rs[10:0]};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    if (!quiet && $urandom_range(3) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every expected sum has come, plus the add latency.
  task automatic drain();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [10:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random beat: mostly ranges inside or near the window, some anywhere in 11 bits.
  task automatic send_random(input int unsigned lo, input int unsigned hi);
    int unsigned rs, re;
    logic [31:0] amt;
    if ($urandom_range(5) == 0) begin
      rs = $urandom_range(2047);
      re = $urandom_range(2047);
    end else begin
      rs = $urandom_range(hi + 2, (lo > 2) ? lo - 2 : 0);
      re = $urandom_range(hi + 2, (lo > 2) ? lo - 2 : 0);
      if (rs > re && $urandom_range(3) != 0) {rs, re} = {re, rs};
    end
    case ($urandom_range(3))
      0: amt = $urandom();
      1: amt = $urandom_range(7);
      2: amt = -$urandom_range(7);
      default: amt = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
    send($urandom_range(1) ? lras_pkg::FuncSum : lras_pkg::FuncAdd, rs, re, amt);
  endtask

  initial begin
    int unsigned ws [9] = '{0, 1000, 0, 5, 2047, 512, 0, 100, 0};
    int unsigned we [9] = '{1024, 1024, 1, 3, 2047, 2047, 2047, 300, 1024};
    int unsigned lo, hi;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes and the special cases on the reset window.
    send(lras_pkg::FuncAdd, 0, 1024, 32'h7FFF_FFFF);
    send(lras_pkg::FuncAdd, 0, 2047, 32'h8000_0000);
    send(lras_pkg::FuncAdd, 5, 5, 32'h1234_5678);
    send(lras_pkg::FuncAdd, 7, 3, 32'h0000_0001);
    send(lras_pkg::FuncSum, 0, 1024, '0);
    send(lras_pkg::FuncSum, 1023, 1024, '0);
    send(lras_pkg::FuncSum, 0, 1, 32'hFFFF_FFFF);
    send(lras_pkg::FuncSum, 1024, 2047, '0);
    send(lras_pkg::FuncSum, 2047, 0, '0);
    send(lras_pkg::FuncSum, 9, 9, '0);
    send(lras_pkg::FuncAdd, 1000, 1024, 32'hFFFF_FFFF);
    send(lras_pkg::FuncAdd, 1, 1022, 32'h5555_5555);
    send(lras_pkg::FuncAdd, 512, 513, 32'hAAAA_AAAA);
    send(lras_pkg::FuncSum, 999, 1001, '0);
    send(lras_pkg::FuncSum, 511, 514, '0);
    send(lras_pkg::FuncSum, 0, 2047, '0);
    send(lras_pkg::FuncSum, 1023, 1025, '0);
    drain();

    for (int p = 0; p < 9; p++) begin
      if (p != 0) begin
        write_reg(lras_pkg::RegWinStart, ws[p][10:0]);
        write_reg(lras_pkg::RegWinEnd, we[p][10:0]);
      end
      lo = ws[p] & 10'h3FF;
      hi = we[p];
      if (hi > lo + lras_pkg::Size) hi = lo + lras_pkg::Size;
      if (hi < lo) hi = lo;
      if (p == 8) quiet = 1'b1;
      if (p == 1) hold_req = 1'b1;
      for (int i = 0; i < 100; i++) begin
        send_random(lo, hi);
        // Pause mid-phase until every sum is back.
        if (i == 50 && p == 2) drain();
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== lazy_range_add_range_sum_unit.f =====
+incdir+hdl
hdl/lras_pkg.sv
hdl/lras_dp.sv
hdl/lras_ctrl.sv
hdl/lazy_range_add_range_sum_unit.sv
hdl/lras_checker.sv
tb/sv/lras_checker.sv
tb/sv/testbench.sv
